// ===== src/name_hash_sorted_lookup_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the name hash lookup core.
// Every assertion in the project is written with one of these macros.
// ----------------------------------------------------------------------------
`ifndef NAME_HASH_SORTED_LOOKUP_CORE_MACROS_SVH
`define NAME_HASH_SORTED_LOOKUP_CORE_MACROS_SVH

// This check is disabled while reset is asserted.
`define NHSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// This check also runs during reset, for properties about reset itself.
`define NHSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/nhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// nhsl_pkg
// Shared types, operation codes and the character fold for the name hash
// lookup core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nhsl_pkg;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SEED  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [31:0] HASH_MULT   = 32'd101;
    localparam logic [7:0]  CH_DOT      = 8'h2E;
    localparam logic [7:0]  CH_SLASH    = 8'h2F;
    localparam logic [7:0]  CH_BSLASH   = 8'h5C;
    localparam logic [7:0]  CH_UPPER_A  = 8'h41;
    localparam logic [7:0]  CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    // Maps path separators to a dot, folds upper case to lower case and
    // sign-extends the result as a signed character.
    function automatic logic [31:0] fold_char(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b == CH_SLASH || b == CH_BSLASH) begin
            c = CH_DOT;
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            c = b + CASE_OFFSET;
        end
        return {{24{c[7]}}, c};
    endfunction

endpackage

`default_nettype wire

// ===== src/name_hash_sorted_lookup_core.sv =====
// ----------------------------------------------------------------------------
// name_hash_sorted_lookup_core
// Hashes a streamed name and looks the hash up in a sorted key table.
//
// Software first loads the key table (op 0, one slot per item, keys in
// ascending order) and sets entry_count and seed through the configuration
// port. Name bytes (op 1) are then taken one per clock cycle while no lookup
// is in progress; each is folded into a running hash as hash*101 plus the
// mapped character, and the hash in force just before the last dot of the
// name is kept. An end-of-name item (op 2) starts a binary search of the
// table and yields exactly one result item with found, found_index and
// name_hash. After a lookup is taken the input is held off while the search
// runs, with at most clog2(n)+1 probes for n entries in use: every probe
// reads the synchronous key memory (ST_READ) and then compares (ST_CMP), a
// miss needs one more ST_READ to see the empty interval, and ST_DONE hands
// the result to the output register. The key memory has a single read
// port. If the previous result still waits in the output register, the
// hand-over and with it the stall last until that result is taken. A
// finished result waits in the output register, so new items are accepted
// while it is not yet taken. Configuration writes are always accepted and
// must only be issued while the block is idle; writing the seed drops any
// name in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module name_hash_sorted_lookup_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input item channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_entry_index,
    input  wire logic [31:0] i_entry_key,
    input  wire logic [7:0]  i_name_byte,
    // Result item channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [7:0]       o_found_index,
    output logic [31:0]      o_name_hash
);

    // Address width of the key memory, search bound width (holds the depth
    // itself) and a common width for range checks of the 8/9-bit fields.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam int CW = AW + 9;

    nhsl_pkg::t_state r_state;
    nhsl_pkg::t_state n_state;

    // Configuration and hashing state.
    logic [31:0] r_seed;
    logic [8:0]  r_entry_count;
    logic [31:0] r_run_hash;
    logic [31:0] r_dot_hash;
    logic        r_dot_seen;

    // Search state.
    logic [31:0]   r_key;
    logic [NW-1:0] r_lo;
    logic [NW-1:0] r_hi;
    logic [AW-1:0] r_mid;
    logic [31:0]   r_rd_data;
    logic          r_hit;

    // Output register.
    logic        r_out_valid;
    logic        r_found;
    logic [7:0]  r_found_index;
    logic [31:0] r_name_hash;

    // Key table: one synchronous memory with a registered read.
    logic [31:0] r_key_mem [TABLE_DEPTH];

    logic          in_acc;
    logic          cfg_acc;
    logic          lookup_acc;
    logic [CW-1:0] idx_ext;
    logic          slot_ok;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] cnt_held;
    logic [NW-1:0] n_lim;
    logic [NW:0]   mid_sum;
    logic [AW-1:0] mid_addr;
    logic          key_lt;
    logic          key_gt;
    logic [AW+7:0] mid_ext;
    logic          out_free;
    logic          rd_en;
    logic          load_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == nhsl_pkg::ST_IDLE);

    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_acc    = i_cfg_valid && o_cfg_ready;
    assign lookup_acc = in_acc && (i_op == nhsl_pkg::OP_LOOKUP);

    // Slot writes beyond the table are dropped.
    assign idx_ext = CW'(i_entry_index);
    assign slot_ok = idx_ext < CW'(TABLE_DEPTH);

    // The number of entries searched is held to the table depth.
    assign cnt_ext  = CW'(r_entry_count);
    assign cnt_held = (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;
    assign n_lim    = cnt_held[NW-1:0];

    // Probe position is the midpoint of the open interval [lo, hi).
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_addr = mid_sum[AW:1];

    assign key_lt   = r_key < r_rd_data;
    assign key_gt   = r_key > r_rd_data;
    assign mid_ext  = (AW + 8)'(r_mid);
    assign out_free = !r_out_valid || i_out_ready;

    // Search sequencer. Writes to the memory happen only in idle, so a
    // probe never overlaps a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nhsl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            nhsl_pkg::ST_IDLE: begin
                if (lookup_acc) begin
                    n_state = nhsl_pkg::ST_READ;
                end
            end
            nhsl_pkg::ST_READ: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    n_state = nhsl_pkg::ST_CMP;
                end else begin
                    n_state = nhsl_pkg::ST_DONE;
                end
            end
            nhsl_pkg::ST_CMP: begin
                if (key_lt || key_gt) begin
                    n_state = nhsl_pkg::ST_READ;
                end else begin
                    n_state = nhsl_pkg::ST_DONE;
                end
            end
            nhsl_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = nhsl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nhsl_pkg::ST_IDLE;
            end
        endcase
    end

    // Key memory write and probe read.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == nhsl_pkg::OP_WRITE) && slot_ok) begin
            r_key_mem[idx_ext[AW-1:0]] <= i_entry_key;
        end
        if (rd_en) begin
            r_rd_data <= r_key_mem[mid_addr];
        end
    end

    // Search bounds and hit flag.
    always_ff @(posedge i_clk) begin
        if (lookup_acc) begin
            r_key <= r_dot_seen ? r_dot_hash : r_seed;
            r_lo  <= '0;
            r_hi  <= n_lim;
            r_hit <= 1'b0;
        end
        if (rd_en) begin
            r_mid <= mid_addr;
        end
        if (r_state == nhsl_pkg::ST_CMP) begin
            if (key_lt) begin
                r_hi <= NW'(r_mid);
            end else if (key_gt) begin
                r_lo <= NW'(r_mid) + NW'(1);
            end else begin
                r_hit <= 1'b1;
            end
        end
    end

    // Configuration registers and the running name hash. A seed write or
    // the start of a lookup reloads the hash for the next name.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= '0;
            r_entry_count <= '0;
            r_run_hash    <= '0;
            r_dot_hash    <= '0;
            r_dot_seen    <= 1'b0;
        end else begin
            if (cfg_acc && (i_cfg_index == nhsl_pkg::CFG_COUNT)) begin
                r_entry_count <= i_cfg_data[8:0];
            end
            priority if (cfg_acc && (i_cfg_index == nhsl_pkg::CFG_SEED)) begin
                r_seed     <= i_cfg_data;
                r_run_hash <= i_cfg_data;
                r_dot_hash <= i_cfg_data;
                r_dot_seen <= 1'b0;
            end else if (lookup_acc) begin
                r_run_hash <= r_seed;
                r_dot_hash <= r_seed;
                r_dot_seen <= 1'b0;
            end else if (in_acc && (i_op == nhsl_pkg::OP_BYTE)) begin
                if (i_name_byte == nhsl_pkg::CH_DOT) begin
                    r_dot_hash <= r_run_hash;
                    r_dot_seen <= 1'b1;
                end
                r_run_hash <= r_run_hash * nhsl_pkg::HASH_MULT
                              + nhsl_pkg::fold_char(i_name_byte);
            end
        end
    end

    // Output register: loaded from the finished search, held until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_found       <= r_hit;
            r_found_index <= r_hit ? mid_ext[7:0] : 8'd0;
            r_name_hash   <= r_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;
    assign o_name_hash   = r_name_hash;

endmodule

`default_nettype wire

// ===== src/nhsl_checker.sv =====
// ----------------------------------------------------------------------------
// nhsl_checker
// Port-level checks of the name hash lookup core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "name_hash_sorted_lookup_core_macros.svh"

module nhsl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [1:0]  i_op,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_found,
    input wire logic [7:0]  o_found_index,
    input wire logic [31:0] o_name_hash
);

    logic        in_lookup;
    logic        out_stall;
    logic        out_miss;
    logic [40:0] out_payload;

    assign in_lookup   = i_in_valid && o_in_ready && (i_op == nhsl_pkg::OP_LOOKUP);
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_miss    = o_out_valid && !o_found;
    assign out_payload = {o_found, o_found_index, o_name_hash};

    // Reset empties the output register.
    `NHSL_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    // A miss always reports slot zero.
    `NHSL_ASSERT(a_miss_index, i_clk, i_rst_n, out_miss |-> o_found_index == 8'd0, "miss index")

    // A lookup item holds off the input while the search runs.
    `NHSL_ASSERT(a_lookup_stalls, i_clk, i_rst_n, in_lookup |=> !o_in_ready, "input open")

    // A stalled result stays offered and keeps its value.
    `NHSL_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid, "stalled result dropped")
    `NHSL_ASSERT(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(out_payload), "result changed")

endmodule

bind name_hash_sorted_lookup_core nhsl_checker u_nhsl_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the name hash lookup core against a cycle-free predictor of the
// hash fold and the binary search. A short directed part drives the
// boundary cases. Random epochs follow, most of which load a sorted key
// table built partly from the hashes of names that are streamed in later.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH   = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;  // spare op code, the core ignores it
    localparam int NAME_SET      = 6;         // names per epoch that can hit the table
    localparam int NAME_MAX      = 12;        // longest random name in bytes
    localparam int ITEM_TARGET   = 1050;      // epochs start until this many items went in
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_NS    = 5000000;

    // One result item of the core.
    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [31:0] hash;
    } t_lookup_result;

    // Mirrors the core state, predicts each lookup result and checks the
    // results in order.
    class lookup_scoreboard;
        logic [31:0]    keys [TABLE_DEPTH];
        logic [31:0]    seed;
        logic [8:0]     entry_count;
        logic [31:0]    running_hash;
        logic [31:0]    hash_at_dot;
        bit             dot_seen;
        t_lookup_result expected_q [$];
        int             failures;

        function new();
            foreach (keys[i]) keys[i] = '0;
            seed        = '0;
            entry_count = '0;
            failures    = 0;
            restart_name();
        endfunction

        function void restart_name();
            running_hash = seed;
            hash_at_dot  = seed;
            dot_seen     = 1'b0;
        endfunction

        // Key of the name so far: the hash in force before its last dot, or the seed if it has no dot.
        function logic [31:0] current_key();
            return dot_seen ? hash_at_dot : seed;
        endfunction

        function logic [31:0] fold(input logic [31:0] h, input logic [7:0] b);
            logic [7:0] c;
            c = b;
            if (b == nhsl_pkg::CH_SLASH || b == nhsl_pkg::CH_BSLASH) begin
                c = nhsl_pkg::CH_DOT;
            end else if (b >= nhsl_pkg::CH_UPPER_A && b <= nhsl_pkg::CH_UPPER_Z) begin
                c = b + nhsl_pkg::CASE_OFFSET;
            end
            return h * nhsl_pkg::HASH_MULT + {{24{c[7]}}, c};
        endfunction

        function t_lookup_result search(input logic [31:0] key);
            t_lookup_result r;
            int lo;
            int hi;
            int mid;
            r      = '0;
            r.hash = key;
            lo     = 0;
            hi     = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (key < keys[mid]) begin
                    hi = mid;
                end else if (key > keys[mid]) begin
                    lo = mid + 1;
                end else begin
                    r.found = 1'b1;
                    r.slot  = mid[7:0];
                    lo      = hi;
                end
            end
            return r;
        endfunction

        function void note_config(input logic index, input logic [31:0] data);
            if (index == nhsl_pkg::CFG_SEED) begin
                seed = data;
                restart_name();
            end else begin
                entry_count = data[8:0];
            end
        endfunction

        function void note_item(input logic [1:0] op, input logic [7:0] slot,
                                input logic [31:0] key, input logic [7:0] b);
            case (op)
                nhsl_pkg::OP_WRITE: begin
                    keys[slot] = key;
                end
                nhsl_pkg::OP_BYTE: begin
                    if (b == nhsl_pkg::CH_DOT) begin
                        hash_at_dot = running_hash;
                        dot_seen    = 1'b1;
                    end
                    running_hash = fold(running_hash, b);
                end
                nhsl_pkg::OP_LOOKUP: begin
                    expected_q.push_back(search(current_key()));
                    restart_name();
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(input logic found, input logic [7:0] slot,
                                   input logic [31:0] hash);
            t_lookup_result want;
            if (expected_q.size() == 0) begin
                if (failures < 10) begin
                    $display("ERROR: result found=%0d slot=%0d hash=%08h with no lookup waiting",
                             found, slot, hash);
                end
                failures++;
            end else begin
                want = expected_q.pop_front();
                if (found !== want.found || slot !== want.slot || hash !== want.hash) begin
                    if (failures < 10) begin
                        $display("ERROR: expected found=%0d slot=%0d hash=%08h, got %0d %0d %08h",
                                 want.found, want.slot, want.hash, found, slot, hash);
                    end
                    failures++;
                end
            end
        endfunction

        // Expectations still waiting at the end are failures.
        function void close();
            if (expected_q.size() != 0) begin
                $display("ERROR: %0d lookup results never arrived", expected_q.size());
            end
            failures += expected_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [31:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_op          = nhsl_pkg::OP_WRITE;
    logic [7:0]  i_entry_index = '0;
    logic [31:0] i_entry_key   = '0;
    logic [7:0]  i_name_byte   = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [7:0]  o_found_index;
    logic [31:0] o_name_hash;

    lookup_scoreboard sb;

    // Idle percentages of the current phase, and accepted items that count
    // toward the item target.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;

    // Name store. The last row is scratch space for one-off names.
    logic [7:0] name_text [0:NAME_SET][0:NAME_MAX-1];
    int         name_len  [0:NAME_SET];

    name_hash_sorted_lookup_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_entry_index(i_entry_index),
        .i_entry_key  (i_entry_key),
        .i_name_byte  (i_name_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_found_index(o_found_index),
        .o_name_hash  (o_name_hash)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver decides once per cycle, on the falling edge, whether it
    // takes a result at the next rising edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Results are sampled at the rising edge, before the core updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_found, o_found_index, o_name_hash);
        end
    end

    // Offers one item and returns at the falling edge after it was taken.
    // Valid is left high so that the next item can follow without a gap;
    // the caller lowers it only by idling or draining.
    task automatic send_item(input logic [1:0] op, input logic [7:0] slot,
                             input logic [31:0] key, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_index <= slot;
        i_entry_key   <= key;
        i_name_byte   <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(op, slot, key, b);
        if (op != OP_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    // Fields an op does not use carry random values.
    task automatic put_entry(input int slot, input logic [31:0] key);
        send_item(nhsl_pkg::OP_WRITE, 8'(slot), key, 8'($urandom));
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_item(nhsl_pkg::OP_BYTE, 8'($urandom), $urandom, b);
    endtask

    task automatic put_lookup();
        send_item(nhsl_pkg::OP_LOOKUP, 8'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic put_noise();
        send_item(OP_UNUSED, 8'($urandom), $urandom, 8'($urandom));
    endtask

    // Stops offering items, waits until every expected result has arrived
    // and then lets the core settle for as long as the settle argument asks.
    task automatic wait_for_quiet(input int settle);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (settle) @(negedge i_clk);
    endtask

    // Register writes are only issued while the core is idle.
    task automatic write_cfg(input logic index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Bytes are drawn so that separators, dots, both cases, zero and the
    // upper half of the byte range all come up often.
    function automatic logic [7:0] pick_name_byte();
        case ($urandom_range(9))
            0:       return nhsl_pkg::CH_DOT;
            1:       return nhsl_pkg::CH_SLASH;
            2:       return nhsl_pkg::CH_BSLASH;
            3:       return 8'($urandom_range(nhsl_pkg::CH_UPPER_Z, nhsl_pkg::CH_UPPER_A));
            4, 5:    return 8'($urandom_range(8'h7A, 8'h61));
            6:       return 8'h00;
            7:       return 8'($urandom_range(8'hFF, 8'h80));
            default: return 8'($urandom_range(8'hFF, 8'h00));
        endcase
    endfunction

    task automatic make_name(input int slot);
        name_len[slot] = $urandom_range(NAME_MAX, 0);
        for (int i = 0; i < name_len[slot]; i++) begin
            name_text[slot][i] = pick_name_byte();
        end
        // Most names get an extension, so the hash before the dot matters.
        if (name_len[slot] > 1 && $urandom_range(9) < 7) begin
            name_text[slot][$urandom_range(name_len[slot] - 1, 1)] = nhsl_pkg::CH_DOT;
        end
    endtask

    // Hash that a stored name would give under the given seed, worked out
    // on a private copy of the predictor.
    function automatic logic [31:0] name_key(input int slot, input logic [31:0] s);
        lookup_scoreboard probe;
        probe = new();
        probe.note_config(nhsl_pkg::CFG_SEED, s);
        for (int i = 0; i < name_len[slot]; i++) begin
            probe.note_item(nhsl_pkg::OP_BYTE, 8'h00, 32'h0, name_text[slot][i]);
        end
        return probe.current_key();
    endfunction

    // Streams a stored name and ends it with a lookup. Spare op codes and
    // stray table writes are sprinkled in now and then.
    task automatic send_name(input int slot);
        for (int i = 0; i < name_len[slot]; i++) begin
            if ($urandom_range(24) == 0) put_noise();
            if ($urandom_range(49) == 0) put_entry($urandom_range(TABLE_DEPTH - 1), $urandom);
            put_byte(name_text[slot][i]);
        end
        put_lookup();
    endtask

    // One random epoch: pick the idling, maybe a new seed, an entry count,
    // usually a fresh sorted table holding the hashes of this epoch's names,
    // and then a run of names of which most should be found.
    task automatic run_epoch(input int e);
        logic [31:0] sorted_keys [$];
        logic [31:0] k;
        int          used;
        int          pos;
        int          names;
        int          pick;
        int          slot;
        bit          rewrite;
        case (e % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
        endcase
        wait_for_quiet(SETTLE_CYCLES);
        if (e % 3 == 0) write_cfg(nhsl_pkg::CFG_SEED, $urandom);
        rewrite = 1'b1;
        case (e)
            1: begin
                used = TABLE_DEPTH;
                write_cfg(nhsl_pkg::CFG_COUNT, TABLE_DEPTH);
            end
            2: begin
                // An oversized count searches the whole full table of the
                // last epoch, whose names are kept so they still hit.
                used    = 0;
                rewrite = 1'b0;
                write_cfg(nhsl_pkg::CFG_COUNT, $urandom_range(511, TABLE_DEPTH + 1));
            end
            3: begin
                used = 0;
                write_cfg(nhsl_pkg::CFG_COUNT, 0);
            end
            default: begin
                used = ($urandom_range(1) == 1) ? $urandom_range(3, 1) : $urandom_range(24, 4);
                write_cfg(nhsl_pkg::CFG_COUNT, used);
            end
        endcase
        if (rewrite) begin
            for (int i = 0; i < NAME_SET; i++) make_name(i);
            for (int i = 0; i < used; i++) begin
                if (i < NAME_SET) begin
                    k = name_key(i, sb.seed);
                end else if (i == NAME_SET) begin
                    k = 32'h0000_0000;
                end else if (i == NAME_SET + 1) begin
                    k = 32'hFFFF_FFFF;
                end else begin
                    k = $urandom;
                end
                pos = 0;
                while (pos < sorted_keys.size() && sorted_keys[pos] < k) pos++;
                sorted_keys.insert(pos, k);
            end
            for (int i = 0; i < used; i++) put_entry(i, sorted_keys[i]);
        end
        names = $urandom_range(30, 15);
        for (int j = 0; j < names; j++) begin
            pick = $urandom_range(19);
            if (pick < 2) begin
                name_len[NAME_SET] = 0;
                slot = NAME_SET;
            end else if (pick < 6) begin
                make_name(NAME_SET);
                slot = NAME_SET;
            end else begin
                slot = $urandom_range(NAME_SET - 1);
            end
            send_name(slot);
            // Now and then the sender holds back until every result is in.
            if ($urandom_range(19) == 0) wait_for_quiet(0);
        end
    endtask

    initial begin
        int epoch;
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every slot is written once, in ascending order, before any lookup,
        // so that no search can ever read a slot that holds nothing.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) begin
                put_entry(i, 32'h0000_0000);
            end else if (i == TABLE_DEPTH - 1) begin
                put_entry(i, 32'hFFFF_FFFF);
            end else begin
                put_entry(i, (i << 24) | $urandom_range(24'hFF_FFFF));
            end
        end

        // Empty table: nothing can be found.
        put_lookup();

        // Full table: an empty name under seed zero lands on the first slot,
        // and under an all-ones seed on the last one.
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_COUNT, TABLE_DEPTH);
        put_lookup();
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_SEED, 32'hFFFF_FFFF);
        put_lookup();
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_SEED, 32'h0000_0000);

        // Upper case, a slash and an extension.
        put_byte("A");
        put_byte(nhsl_pkg::CH_SLASH);
        put_byte("b");
        put_byte(nhsl_pkg::CH_DOT);
        put_byte("c");
        put_lookup();

        // A zero byte, bytes in the upper half, and several dots of which
        // only the last counts; a backslash after it is a mapped dot only.
        put_byte(8'h00);
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(nhsl_pkg::CH_DOT);
        put_byte("Z");
        put_byte(nhsl_pkg::CH_DOT);
        put_byte(nhsl_pkg::CH_BSLASH);
        put_lookup();

        // No literal dot: the name hashes to the seed and hits slot zero.
        put_byte("x");
        put_byte(nhsl_pkg::CH_BSLASH);
        put_byte("y");
        put_lookup();
        put_noise();

        // A seed write in the middle of a name drops the bytes seen so far.
        put_byte("a");
        put_byte(nhsl_pkg::CH_DOT);
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_SEED, 32'h0000_0000);
        put_lookup();

        // A count beyond the table is held to its depth.
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_COUNT, 9'h1FF);
        put_byte("q");
        put_lookup();

        // Keys in descending order: the search misses a key that is there.
        put_entry(0, 32'd40);
        put_entry(1, 32'd30);
        put_entry(2, 32'd20);
        put_entry(3, 32'd10);
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_COUNT, 4);
        write_cfg(nhsl_pkg::CFG_SEED, 32'd10);
        put_lookup();

        // Repeated keys: the first probe already matches.
        put_entry(0, 32'd7);
        put_entry(1, 32'd7);
        put_entry(2, 32'd7);
        put_entry(3, 32'd7);
        wait_for_quiet(SETTLE_CYCLES);
        write_cfg(nhsl_pkg::CFG_SEED, 32'd7);
        put_lookup();

        epoch = 0;
        while (items_sent < ITEM_TARGET) begin
            run_epoch(epoch);
            epoch++;
        end

        wait_for_quiet(SETTLE_CYCLES);
        sb.close();
        if (sb.failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== name_hash_sorted_lookup_core.f =====
+incdir+src
src/nhsl_pkg.sv
src/name_hash_sorted_lookup_core.sv
src/nhsl_checker.sv
sim/testbench.sv
